/* rtl/core/coo2csc_pkg.sv */
// ----------------------------------------------------------------------------
// coo2csc_pkg
// Shared types and codes of the triplet to compressed-column converter.
// ----------------------------------------------------------------------------
package coo2csc_pkg;

  localparam int FUNC_W = 3;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;
  localparam int VAL_W  = 64;
  localparam int IDX_W  = 11;
  localparam int NCOL_W = 11;
  localparam int STAT_W = 2;
  localparam int PTR_W  = 11;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPRESS = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_PTR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RD_ENTRY = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_LOAD_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_READ_ERR = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PTR_W-1:0]  pointer;
    logic [ROW_W-1:0]  row_out;
    logic [VAL_W-1:0]  value_out;
  } rsp_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } load_entry_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] value;
  } packed_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_FRD,
    ST_CNT_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_SCT_RD,
    ST_SCT_FRD,
    ST_SCT_WR
  } state_t;

  typedef enum logic [1:0] {
    RK_REG,
    RK_PTR,
    RK_ENT
  } res_kind_t;

  typedef struct packed {
    logic accept;
    logic clr;
    logic cnt_rd;
    logic cnt_frd;
    logic cnt_wr;
    logic pfx_rd;
    logic pfx_wr;
    logic sct_rd;
    logic sct_frd;
    logic sct_wr;
  } cmd_t;

  typedef struct packed {
    logic c_end;
    logic k_end;
    logic col_in_range;
  } dp_stat_t;

endpackage

/* rtl/core/coo2csc_ram.sv */
// ----------------------------------------------------------------------------
// coo2csc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module coo2csc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/coo2csc_ctrl.sv */
// ----------------------------------------------------------------------------
// coo2csc_ctrl
// Controller: accepts items and sequences the compress passes.
// ----------------------------------------------------------------------------
module coo2csc_ctrl
  import coo2csc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  dp_stat_t          stat,
  output cmd_t              cmd,
  output logic              busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && func == FUNC_COMPRESS) begin
          state_next = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (stat.c_end) begin
          state_next = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = stat.k_end ? ST_PFX_RD : ST_CNT_FRD;
      end
      ST_CNT_FRD: begin
        cmd.cnt_frd = 1'b1;
        state_next  = stat.col_in_range ? ST_CNT_WR : ST_CNT_RD;
      end
      ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_next = ST_CNT_RD;
      end
      ST_PFX_RD: begin
        cmd.pfx_rd = 1'b1;
        state_next = stat.c_end ? ST_SCT_RD : ST_PFX_WR;
      end
      ST_PFX_WR: begin
        cmd.pfx_wr = 1'b1;
        state_next = ST_PFX_RD;
      end
      ST_SCT_RD: begin
        cmd.sct_rd = 1'b1;
        state_next = stat.k_end ? ST_IDLE : ST_SCT_FRD;
      end
      ST_SCT_FRD: begin
        cmd.sct_frd = 1'b1;
        state_next  = stat.col_in_range ? ST_SCT_WR : ST_SCT_RD;
      end
      ST_SCT_WR: begin
        cmd.sct_wr = 1'b1;
        state_next = ST_SCT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

/* rtl/core/coo2csc_dp.sv */
// ----------------------------------------------------------------------------
// coo2csc_dp
// Datapath: triplet store, column counters, column pointers, packed entries.
// ----------------------------------------------------------------------------
module coo2csc_dp
  import coo2csc_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_COLS    = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  req_t              req,
  input  logic              cfg_we,
  input  logic [NCOL_W-1:0] cfg_wdata,
  input  cmd_t              cmd,
  output dp_stat_t          stat,
  output logic              done,
  output rsp_t              rsp
);

  localparam int EW  = $clog2(MAX_ENTRIES);
  localparam int TCW = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NCW = $clog2(MAX_COLS + 1);

  logic [NCOL_W-1:0] num_cols;
  logic [NCW-1:0]    ncols;
  logic [TCW-1:0]    triplet_count;
  logic              compressed;
  logic [TCW-1:0]    k;
  logic [NCW-1:0]    c;
  logic [TCW-1:0]    total;
  logic              dropped;
  res_kind_t         res_kind;
  logic [STAT_W-1:0] res_status;
  logic [PTR_W-1:0]  res_pointer;

  logic          load_we, load_re;
  logic [EW-1:0] load_waddr, load_raddr;
  load_entry_t   load_wdata, load_q;

  logic           fill_we, fill_re;
  logic [CW-1:0]  fill_waddr, fill_raddr;
  logic [TCW-1:0] fill_wdata, fill_q;

  logic           starts_re;
  logic [TCW-1:0] starts_q;

  logic          packed_re;
  packed_entry_t packed_q;

  logic load_ok;

  assign ncols = (32'(num_cols) > 32'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(num_cols);

  assign stat.c_end        = (c == ncols);
  assign stat.k_end        = (k == triplet_count);
  assign stat.col_in_range = (32'(load_q.col) < 32'(ncols));

  assign load_ok = (32'(triplet_count) < 32'(MAX_ENTRIES)) && (32'(req.col) < 32'(ncols));

  always_comb begin
    load_we    = cmd.accept && req.func == FUNC_LOAD && load_ok;
    load_waddr = EW'(triplet_count);
    load_wdata = '{row: req.row, col: req.col, value: req.value};
    load_re    = (cmd.cnt_rd || cmd.sct_rd) && !stat.k_end;
    load_raddr = EW'(k);

    fill_we    = 1'b0;
    fill_waddr = CW'(load_q.col);
    fill_wdata = fill_q + TCW'(1);
    fill_re    = 1'b0;
    fill_raddr = CW'(load_q.col);
    if (cmd.clr && !stat.c_end) begin
      fill_we    = 1'b1;
      fill_waddr = CW'(c);
      fill_wdata = '0;
    end
    if (cmd.cnt_wr || cmd.sct_wr) begin
      fill_we = 1'b1;
    end
    if (cmd.pfx_wr) begin
      fill_we    = 1'b1;
      fill_waddr = CW'(c);
      fill_wdata = total;
    end
    if ((cmd.cnt_frd || cmd.sct_frd) && stat.col_in_range) begin
      fill_re = 1'b1;
    end
    if (cmd.pfx_rd && !stat.c_end) begin
      fill_re    = 1'b1;
      fill_raddr = CW'(c);
    end

    starts_re = 1'b0;
    packed_re = 1'b0;
    if (cmd.accept && compressed) begin
      starts_re = (req.func == FUNC_RD_PTR) && (32'(req.index) < 32'(ncols));
      packed_re = (req.func == FUNC_RD_ENTRY) && (32'(req.index) < 32'(total));
    end
  end

  coo2csc_ram #(.WIDTH($bits(load_entry_t)), .DEPTH(MAX_ENTRIES)) u_load_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_waddr),
    .wdata (load_wdata),
    .re    (load_re),
    .raddr (load_raddr),
    .rdata (load_q)
  );

  coo2csc_ram #(.WIDTH(TCW), .DEPTH(MAX_COLS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (fill_raddr),
    .rdata (fill_q)
  );

  coo2csc_ram #(.WIDTH(TCW), .DEPTH(MAX_COLS)) u_starts_ram (
    .clk   (clk),
    .we    (cmd.pfx_wr),
    .waddr (CW'(c)),
    .wdata (total),
    .re    (starts_re),
    .raddr (CW'(req.index)),
    .rdata (starts_q)
  );

  coo2csc_ram #(.WIDTH($bits(packed_entry_t)), .DEPTH(MAX_ENTRIES)) u_packed_ram (
    .clk   (clk),
    .we    (cmd.sct_wr),
    .waddr (EW'(fill_q)),
    .wdata ({load_q.row, load_q.value}),
    .re    (packed_re),
    .raddr (EW'(req.index)),
    .rdata (packed_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols      <= '0;
      triplet_count <= '0;
      compressed    <= 1'b0;
      k             <= '0;
      c             <= '0;
      total         <= '0;
      dropped       <= 1'b0;
      done          <= 1'b0;
      res_kind      <= RK_REG;
      res_status    <= STATUS_OK;
      res_pointer   <= '0;
    end else begin
      done <= 1'b0;

      if (cmd.accept) begin
        done        <= (req.func != FUNC_COMPRESS);
        res_kind    <= RK_REG;
        res_status  <= STATUS_OK;
        res_pointer <= '0;
        case (req.func)
          FUNC_CLEAR: begin
            triplet_count <= '0;
            compressed    <= 1'b0;
          end
          FUNC_LOAD: begin
            if (load_ok) begin
              triplet_count <= triplet_count + TCW'(1);
              compressed    <= 1'b0;
            end else begin
              res_status <= STATUS_LOAD_ERR;
            end
          end
          FUNC_COMPRESS: begin
            c       <= '0;
            total   <= '0;
            dropped <= 1'b0;
          end
          FUNC_RD_PTR: begin
            if (!compressed || 32'(req.index) > 32'(ncols)) begin
              res_status <= STATUS_READ_ERR;
            end else if (32'(req.index) == 32'(ncols)) begin
              res_pointer <= PTR_W'(total);
            end else begin
              res_kind <= RK_PTR;
            end
          end
          FUNC_RD_ENTRY: begin
            if (!compressed || 32'(req.index) >= 32'(total)) begin
              res_status <= STATUS_READ_ERR;
            end else begin
              res_kind <= RK_ENT;
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.clr) begin
        if (stat.c_end) begin
          k <= '0;
        end else begin
          c <= c + NCW'(1);
        end
      end
      if (cmd.cnt_rd && stat.k_end) begin
        c <= '0;
      end
      if (cmd.cnt_frd && !stat.col_in_range) begin
        dropped <= 1'b1;
        k       <= k + TCW'(1);
      end
      if (cmd.sct_frd && !stat.col_in_range) begin
        k <= k + TCW'(1);
      end
      if (cmd.cnt_wr || cmd.sct_wr) begin
        k <= k + TCW'(1);
      end
      if (cmd.pfx_rd && stat.c_end) begin
        k <= '0;
      end
      if (cmd.pfx_wr) begin
        total <= total + fill_q;
        c     <= c + NCW'(1);
      end
      if (cmd.sct_rd && stat.k_end) begin
        compressed  <= 1'b1;
        done        <= 1'b1;
        res_kind    <= RK_REG;
        res_status  <= dropped ? STATUS_LOAD_ERR : STATUS_OK;
        res_pointer <= '0;
      end

      if (cfg_we) begin
        num_cols   <= cfg_wdata;
        compressed <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.status    = res_status;
    rsp.pointer   = res_pointer;
    rsp.row_out   = '0;
    rsp.value_out = '0;
    case (res_kind)
      RK_PTR: begin
        rsp.pointer = PTR_W'(starts_q);
      end
      RK_ENT: begin
        rsp.row_out   = packed_q.row;
        rsp.value_out = packed_q.value;
      end
      default: begin
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_imm_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && req.func != FUNC_COMPRESS) |=> done)
    else $error("no result beat after an immediate item");

  a_scatter_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sct_wr |-> (32'(fill_q) < 32'(total)))
    else $error("scatter slot beyond entry total");

  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pfx_wr |-> (32'(c) < 32'(ncols)))
    else $error("column pointer written beyond column count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(triplet_count) <= 32'(MAX_ENTRIES))
    else $error("triplet count beyond store depth");

endmodule

/* rtl/core/coo_to_csc_sparse_compress_unit.sv */
// ----------------------------------------------------------------------------
// coo_to_csc_sparse_compress_unit
// Clear, load, compress and read-back items each give one result beat, marked
// by done, which the receiver must take in that cycle. Clear, load and read
// items leave busy low: a new item may follow at once and its result
// appears the cycle after acceptance. Compress holds busy high while it
// runs its passes, which are set by the registered read of the triplet
// store and of the per-column count memory; every in-range triplet passes
// through that memory twice in read-modify-write. The compress result
// appears in the first cycle with busy low. Write num_cols only while idle.
// ----------------------------------------------------------------------------
module coo_to_csc_sparse_compress_unit
  import coo2csc_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_COLS    = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [NCOL_W-1:0] cfg_wdata
);

  cmd_t     cmd;
  dp_stat_t stat;

  coo2csc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (req.func),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  coo2csc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_COLS    (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

/* bench/coo2csc_checker.sv */
// ----------------------------------------------------------------------------
// coo2csc_checker
// Watches the command, result and column-count ports of the triplet to
// compressed-column converter. Keeps its own copy of the triplet store, the
// column pointers and the compressed entries, and works out the result beat
// of every accepted command. Each result beat is compared field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module coo2csc_checker
  import coo2csc_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int MAX_COLS    = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  req_t              req,
  input  logic              done,
  input  rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [NCOL_W-1:0] cfg_wdata,
  output int unsigned       mismatches,
  output int unsigned       outstanding,
  output int unsigned       compared
);

  logic [ROW_W-1:0]  trip_row [MAX_ENTRIES];
  logic [COL_W-1:0]  trip_col [MAX_ENTRIES];
  logic [VAL_W-1:0]  trip_val [MAX_ENTRIES];
  int unsigned       trip_n;
  int unsigned       col_start  [MAX_COLS+1];
  int unsigned       col_cursor [MAX_COLS];
  logic [ROW_W-1:0]  csc_row [MAX_ENTRIES];
  logic [VAL_W-1:0]  csc_val [MAX_ENTRIES];
  bit                csc_valid;
  logic [NCOL_W-1:0] ncols;
  rsp_t              due_results [$];
  rsp_t              wanted;
  int unsigned       fail_n;
  int unsigned       match_n;

  assign mismatches = fail_n;
  assign compared   = match_n;

  function automatic int unsigned cols_in_use();
    return (ncols > MAX_COLS) ? MAX_COLS : ncols;
  endfunction

  function automatic rsp_t csc_result(input req_t r);
    rsp_t        res;
    int unsigned nc;
    int unsigned total;
    int unsigned cnt;
    int unsigned slot;
    bit          dropped;
    res = '0;
    nc  = cols_in_use();
    case (r.func)
      FUNC_CLEAR: begin
        trip_n    = 0;
        csc_valid = 1'b0;
      end
      FUNC_LOAD: begin
        if (trip_n >= MAX_ENTRIES || r.col >= nc) begin
          res.status = STATUS_LOAD_ERR;
        end else begin
          trip_row[trip_n] = r.row;
          trip_col[trip_n] = r.col;
          trip_val[trip_n] = r.value;
          trip_n++;
          csc_valid = 1'b0;
        end
      end
      FUNC_COMPRESS: begin
        dropped = 1'b0;
        for (int c = 0; c < MAX_COLS; c++) col_cursor[c] = 0;
        for (int k = 0; k < trip_n; k++) begin
          if (trip_col[k] < nc) col_cursor[trip_col[k]]++;
          else dropped = 1'b1;
        end
        total = 0;
        for (int c = 0; c < nc; c++) begin
          cnt           = col_cursor[c];
          col_start[c]  = total;
          col_cursor[c] = total;
          total        += cnt;
        end
        col_start[nc] = total;
        for (int k = 0; k < trip_n; k++) begin
          if (trip_col[k] < nc) begin
            slot = col_cursor[trip_col[k]];
            col_cursor[trip_col[k]]++;
            if (slot < MAX_ENTRIES) begin
              csc_row[slot] = trip_row[k];
              csc_val[slot] = trip_val[k];
            end
          end
        end
        csc_valid = 1'b1;
        if (dropped) res.status = STATUS_LOAD_ERR;
      end
      FUNC_RD_PTR: begin
        if (!csc_valid || r.index > nc) res.status = STATUS_READ_ERR;
        else res.pointer = col_start[r.index][PTR_W-1:0];
      end
      FUNC_RD_ENTRY: begin
        if (!csc_valid || r.index >= col_start[nc] || r.index >= MAX_ENTRIES) begin
          res.status = STATUS_READ_ERR;
        end else begin
          res.row_out   = csc_row[r.index];
          res.value_out = csc_val[r.index];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag(input string what, input logic [VAL_W-1:0] got,
                      input logic [VAL_W-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h (beat %0d)", what, got, want,
             match_n + fail_n);
    fail_n++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ncols     = '0;
      trip_n    = 0;
      csc_valid = 1'b0;
      due_results.delete();
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          flag("unexpected result beat", VAL_W'(rsp), '0);
        end else begin
          wanted = due_results.pop_front();
          if (rsp.status !== wanted.status) begin
            flag("status", VAL_W'(rsp.status), VAL_W'(wanted.status));
          end
          if (rsp.pointer !== wanted.pointer) begin
            flag("pointer", VAL_W'(rsp.pointer), VAL_W'(wanted.pointer));
          end
          if (rsp.row_out !== wanted.row_out) begin
            flag("row_out", VAL_W'(rsp.row_out), VAL_W'(wanted.row_out));
          end
          if (rsp.value_out !== wanted.value_out) begin
            flag("value_out", rsp.value_out, wanted.value_out);
          end
          match_n++;
        end
      end
      if (cfg_we) begin
        ncols     = cfg_wdata;
        csc_valid = 1'b0;
      end
      if (start && !busy) due_results.insert(due_results.size(), csc_result(req));
    end
    outstanding <= due_results.size();
  end

endmodule

/* bench/coo_to_csc_sparse_compress_unit_test.sv */
// ----------------------------------------------------------------------------
// coo_to_csc_sparse_compress_unit_test
// Drives the converter through a directed pass over empty, saturated and
// lowered column counts, bad read indices and unknown commands, then through
// random clear/load/compress/read sessions of mostly small size, one of them
// filling the triplet store. Sender gaps vary by session; a checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module coo_to_csc_sparse_compress_unit_test;
  import coo2csc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 2030;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  req_t              req;
  logic              done;
  rsp_t              rsp;
  logic              cfg_we;
  logic [NCOL_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned sessions_run = 0;
  int unsigned compresses_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned idle_mix [3] = '{0, 54, 19};

  always #4 clk = ~clk;

  coo_to_csc_sparse_compress_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  coo2csc_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("coo_to_csc_sparse_compress_unit test failed");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] rand_val();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_req(input logic [FUNC_W-1:0] f, input int unsigned rw,
                                    input int unsigned cl, input logic [VAL_W-1:0] v,
                                    input int unsigned ix);
    req_t r;
    r.func  = f;
    r.row   = rw[ROW_W-1:0];
    r.col   = cl[COL_W-1:0];
    r.value = v;
    r.index = ix[IDX_W-1:0];
    return r;
  endfunction

  function automatic req_t noise_req();
    return make_req(FUNC_W'($urandom_range(0, 7)), $urandom, $urandom, rand_val(), $urandom);
  endfunction

  function automatic req_t load_beat(input int unsigned lim);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return noise_req();
    if (roll < 13 || lim == 0) begin
      return make_req(FUNC_LOAD, $urandom, $urandom_range(0, 1023), rand_val(), $urandom);
    end
    return make_req(FUNC_LOAD, $urandom, $urandom_range(0, lim - 1), rand_val(), $urandom);
  endfunction

  function automatic req_t read_beat(input int unsigned lim, input int unsigned n);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return noise_req();
    if (roll < 10) return load_beat(lim);
    if (roll < 20) begin
      return make_req(roll[0] ? FUNC_RD_PTR : FUNC_RD_ENTRY, $urandom, $urandom, rand_val(),
                      $urandom_range(0, 2047));
    end
    if (roll < 55) begin
      return make_req(FUNC_RD_PTR, $urandom, $urandom, rand_val(), $urandom_range(0, lim + 1));
    end
    return make_req(FUNC_RD_ENTRY, $urandom, $urandom, rand_val(), $urandom_range(0, n + 1));
  endfunction

  // hold start until the beat is taken, then idle at random
  task automatic push_item(input req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (r.func == FUNC_COMPRESS) compresses_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic program_cols(input int unsigned v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v[NCOL_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_session(input bit fill_store);
    int unsigned nc;
    int unsigned lim;
    int unsigned n_loads;
    int unsigned n_reads;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (fill_store) nc = 1024;
    else if (roll < 6) nc = 0;
    else if (roll < 12) nc = $urandom_range(1024, 2047);
    else nc = $urandom_range(1, 24);
    program_cols(nc);
    lim = (nc > 1024) ? 1024 : nc;
    if (fill_store || $urandom_range(0, 9) != 0) begin
      push_item(make_req(FUNC_CLEAR, $urandom, $urandom, rand_val(), $urandom));
    end
    if (fill_store) n_loads = 1026;
    else if (roll >= 6 && roll < 12) n_loads = $urandom_range(50, 200);
    else n_loads = $urandom_range(0, 30);
    for (int i = 0; i < n_loads; i++) begin
      if (fill_store) begin
        push_item(make_req(FUNC_LOAD, $urandom, $urandom_range(0, 1023), rand_val(),
                           $urandom));
      end else begin
        push_item(load_beat(lim));
      end
    end
    if (!fill_store && $urandom_range(0, 4) == 0) begin
      nc = $urandom_range(0, nc);
      program_cols(nc);
      lim = (nc > 1024) ? 1024 : nc;
    end
    push_item(make_req(FUNC_COMPRESS, $urandom, $urandom, rand_val(), $urandom));
    n_reads = $urandom_range(4, 40);
    for (int i = 0; i < n_reads; i++) push_item(read_beat(lim, n_loads));
    sessions_run++;
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty column count, reads before compress, unknown commands
    program_cols(0);
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 0));
    push_item(make_req(FUNC_RD_ENTRY, 0, 0, '0, 0));
    push_item(make_req(FUNC_LOAD, 1023, 0, '1, 0));
    push_item(make_req(FUNC_COMPRESS, 0, 0, '0, 0));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 0));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 1));
    push_item(make_req(FUNC_RD_ENTRY, 0, 0, '0, 0));
    push_item(make_req(3'd5, 1023, 1023, '1, 2047));
    push_item(make_req(3'd6, 0, 0, '0, 0));
    push_item(make_req(3'd7, 1023, 1023, '1, 2047));

    // saturated column count, bounds of both read kinds
    program_cols(2047);
    push_item(make_req(FUNC_LOAD, 1023, 1023, '1, 2047));
    push_item(make_req(FUNC_LOAD, 0, 0, '0, 0));
    push_item(make_req(FUNC_LOAD, 1023, 0, 64'hA5A5_5A5A_0F0F_F0F0, 0));
    push_item(make_req(FUNC_COMPRESS, 0, 0, '0, 0));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 1024));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 1025));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 2047));
    push_item(make_req(FUNC_RD_ENTRY, 0, 0, '0, 1));
    push_item(make_req(FUNC_RD_ENTRY, 0, 0, '0, 2));
    push_item(make_req(FUNC_RD_ENTRY, 0, 0, '0, 3));

    // lowered column count drops a triplet; config write and load invalidate
    program_cols(4);
    push_item(make_req(FUNC_COMPRESS, 0, 0, '0, 0));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 4));
    program_cols(4);
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 0));
    push_item(make_req(FUNC_COMPRESS, 0, 0, '0, 0));
    push_item(make_req(FUNC_LOAD, 5, 3, rand_val(), 0));
    push_item(make_req(FUNC_RD_PTR, 0, 0, '0, 0));
    push_item(make_req(FUNC_CLEAR, 0, 0, '0, 0));
    push_item(make_req(FUNC_RD_ENTRY, 0, 0, '0, 0));

    while (items_sent < ITEM_TARGET) begin
      idle_pct = idle_mix[sessions_run % 3];
      run_session(sessions_run == 3);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d commands in %0d random sessions (%0d compresses, one full store).",
             items_sent, sessions_run, compresses_sent);
    $display("Compared %0d result beats, %0d mismatches.", compared, mismatches);
    if (mismatches == 0) begin
      $display("coo_to_csc_sparse_compress_unit test passed");
    end else begin
      $display("coo_to_csc_sparse_compress_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/coo2csc_pkg.sv
rtl/core/coo2csc_ram.sv
rtl/core/coo2csc_ctrl.sv
rtl/core/coo2csc_dp.sv
rtl/core/coo_to_csc_sparse_compress_unit.sv
bench/coo2csc_checker.sv
bench/coo_to_csc_sparse_compress_unit_test.sv
